FILE: hdl/flood_window_source_tracker_core_macros.svh
// Assertion macros used by the checker file.
`ifndef FLOOD_WINDOW_SOURCE_TRACKER_CORE_MACROS_SVH
`define FLOOD_WINDOW_SOURCE_TRACKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FWST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("fwst check failed");

// The consequent must hold in the cycle after the antecedent.
`define FWST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("fwst check failed");

`endif

FILE: hdl/fwst_pkg.sv
`timescale 1ns / 1ps

package fwst_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_ALERT_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS  = 1'b1;

	localparam logic [30:0] ALERT_THRESHOLD_RESET = 31'd100;
	localparam logic [15:0] WINDOW_SECONDS_RESET  = 16'd5;

	localparam logic [7:0] PROTO_TCP = 8'd6;

	typedef enum logic [1:0] {
		KIND_QUIET = 2'd0,
		KIND_ALERT = 2'd1,
		KIND_BLOCK = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_VERDICT,
		ST_DRAIN
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic apply;
		logic restart;
		logic load_verdict;
		logic load_entry;
		logic drain_clear;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic alert;
		logic fill_zero;
		logic drain_last;
		logic out_free;
	} status_t;

endpackage

FILE: hdl/fwst_ifs.sv
`timescale 1ns / 1ps

interface fwst_pkt_if;
	logic        valid;
	logic        ready;
	logic [31:0] arrival_seconds;
	logic [7:0]  ip_protocol;
	logic [31:0] source_addr;

	modport source (output valid, output arrival_seconds, output ip_protocol,
		output source_addr, input ready);
	modport sink (input valid, input arrival_seconds, input ip_protocol,
		input source_addr, output ready);
endinterface

interface fwst_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [31:0] packet_total;
	logic [31:0] blocked_addr;
	logic        last_result;

	modport source (output valid, output result_kind, output packet_total,
		output blocked_addr, output last_result, input ready);
	modport sink (input valid, input result_kind, input packet_total,
		input blocked_addr, input last_result, output ready);
endinterface

FILE: hdl/fwst_datapath.sv
`timescale 1ns / 1ps

module fwst_datapath #(
	parameter int MAX_SOURCES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fwst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fwst_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [31:0]                      in_arrival_seconds,
	input  logic [7:0]                       in_ip_protocol,
	input  logic [31:0]                      in_source_addr,
	input  fwst_pkg::cmd_t                   cmd,
	output fwst_pkg::status_t                status,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [1:0]                       out_kind,
	output logic [31:0]                      out_total,
	output logic [31:0]                      out_addr,
	output logic                             out_last
);

	localparam int FILL_W = $clog2(MAX_SOURCES + 1);
	localparam int IDX_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

	logic [30:0]       thresh_q;
	logic [15:0]       win_sec_q;
	logic [31:0]       item_now_q;
	logic [7:0]        item_proto_q;
	logic [31:0]       item_addr_q;
	logic              open_q;
	logic [31:0]       win_start_q;
	logic [31:0]       pkts_q;
	logic [FILL_W-1:0] fill_q;
	logic [31:0]       src_tbl_q [MAX_SOURCES];
	logic [IDX_W-1:0]  drain_idx_q;
	logic              out_valid_q;
	logic [1:0]        out_kind_q;
	logic [31:0]       out_total_q;
	logic [31:0]       out_addr_q;
	logic              out_last_q;

	logic [31:0] elapsed;
	logic        found;
	logic        is_tcp;
	logic        room;

	assign elapsed = item_now_q - win_start_q;
	assign is_tcp  = (item_proto_q == fwst_pkg::PROTO_TCP);
	assign room    = (fill_q < FILL_W'(MAX_SOURCES));

	always_comb begin
		found = 1'b0;
		for (int i = 0; i < MAX_SOURCES; i++) begin
			if ((FILL_W'(i) < fill_q) && (src_tbl_q[i] == item_addr_q)) begin
				found = 1'b1;
			end
		end
	end

	always_comb begin
		status.close      = open_q && (item_now_q >= win_start_q) &&
			(elapsed >= {16'd0, win_sec_q});
		status.alert      = pkts_q > {1'b0, thresh_q};
		status.fill_zero  = (fill_q == '0);
		status.drain_last = ((FILL_W'(drain_idx_q) + FILL_W'(1)) == fill_q);
		status.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q  <= fwst_pkg::ALERT_THRESHOLD_RESET;
			win_sec_q <= fwst_pkg::WINDOW_SECONDS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fwst_pkg::CFG_ALERT_THRESHOLD: thresh_q  <= cfg_data;
				fwst_pkg::CFG_WINDOW_SECONDS:  win_sec_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_now_q   <= in_arrival_seconds;
			item_proto_q <= in_ip_protocol;
			item_addr_q  <= in_source_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			win_start_q <= '0;
			pkts_q      <= '0;
			fill_q      <= '0;
		end else if (cmd.restart) begin
			win_start_q <= item_now_q;
			pkts_q      <= 32'd1;
			fill_q      <= is_tcp ? FILL_W'(1) : '0;
		end else if (cmd.apply) begin
			if (!open_q) begin
				open_q      <= 1'b1;
				win_start_q <= item_now_q;
			end
			if (is_tcp && !found && room) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (pkts_q != 32'hFFFF_FFFF) begin
				pkts_q <= pkts_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.restart && is_tcp) begin
			src_tbl_q[0] <= item_addr_q;
		end else if (cmd.apply && is_tcp && !found && room) begin
			src_tbl_q[fill_q[IDX_W-1:0]] <= item_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_idx_q <= '0;
		end else if (cmd.drain_clear) begin
			drain_idx_q <= '0;
		end else if (cmd.load_entry) begin
			drain_idx_q <= drain_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_verdict || cmd.load_entry) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_verdict) begin
			out_kind_q  <= status.alert ? fwst_pkg::KIND_ALERT : fwst_pkg::KIND_QUIET;
			out_total_q <= pkts_q;
			out_addr_q  <= '0;
			out_last_q  <= !status.alert || status.fill_zero;
		end else if (cmd.load_entry) begin
			out_kind_q  <= fwst_pkg::KIND_BLOCK;
			out_total_q <= '0;
			out_addr_q  <= src_tbl_q[drain_idx_q];
			out_last_q  <= status.drain_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_total = out_total_q;
	assign out_addr  = out_addr_q;
	assign out_last  = out_last_q;

endmodule

FILE: hdl/fwst_ctrl.sv
`timescale 1ns / 1ps

module fwst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fwst_pkg::status_t status,
	output fwst_pkg::cmd_t    cmd
);

	fwst_pkg::ctrl_state_t state_q;
	fwst_pkg::ctrl_state_t state_d;
	logic                  item_valid_q;
	logic                  item_valid_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fwst_pkg::ST_RUN: begin
				if (item_valid_q && status.close) begin
					state_d = fwst_pkg::ST_VERDICT;
				end
			end
			fwst_pkg::ST_VERDICT: begin
				if (status.out_free) begin
					state_d = (status.alert && !status.fill_zero) ?
						fwst_pkg::ST_DRAIN : fwst_pkg::ST_RUN;
				end
			end
			fwst_pkg::ST_DRAIN: begin
				if (status.out_free && status.drain_last) begin
					state_d = fwst_pkg::ST_RUN;
				end
			end
			default: state_d = fwst_pkg::ST_RUN;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		item_valid_d = item_valid_q;
		case (state_q)
			fwst_pkg::ST_RUN: begin
				in_ready  = !(item_valid_q && status.close);
				cmd.apply = item_valid_q && !status.close;
				cmd.take  = in_valid && in_ready;
				if (in_ready) begin
					item_valid_d = in_valid;
				end
			end
			fwst_pkg::ST_VERDICT: begin
				if (status.out_free) begin
					cmd.load_verdict = 1'b1;
					if (status.alert && !status.fill_zero) begin
						cmd.drain_clear = 1'b1;
					end else begin
						cmd.restart  = 1'b1;
						item_valid_d = 1'b0;
					end
				end
			end
			fwst_pkg::ST_DRAIN: begin
				if (status.out_free) begin
					cmd.load_entry = 1'b1;
					if (status.drain_last) begin
						cmd.restart  = 1'b1;
						item_valid_d = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fwst_pkg::ST_RUN;
			item_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			item_valid_q <= item_valid_d;
		end
	end

endmodule

FILE: hdl/flood_window_source_tracker_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Word
// in_pkt    sink       arrival_seconds, ip_protocol, source_addr
// out_res   source     result_kind, packet_total, blocked_addr, last_result
//
// A packet that leaves its window running is applied while the next one is taken, so
// packets enter back to back. A packet that closes the window holds input off while the
// close is detected, while the verdict is loaded and, on an alert, while each stored
// source is loaded in turn. Output stalls lengthen the hold only while a window reports.
// Reset is asynchronous and clears all control state at once; no clearing pass is needed.
module flood_window_source_tracker_core #(
	parameter int MAX_SOURCES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fwst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fwst_pkg::CFG_DATA_W-1:0] cfg_data,
	fwst_pkt_if.sink                        in_pkt,
	fwst_res_if.source                      out_res
);

	fwst_pkg::cmd_t    cmd;
	fwst_pkg::status_t status;

	fwst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_pkt.valid),
		.in_ready (in_pkt.ready),
		.status   (status),
		.cmd      (cmd)
	);

	fwst_datapath #(
		.MAX_SOURCES (MAX_SOURCES)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_arrival_seconds (in_pkt.arrival_seconds),
		.in_ip_protocol     (in_pkt.ip_protocol),
		.in_source_addr     (in_pkt.source_addr),
		.cmd                (cmd),
		.status             (status),
		.out_ready          (out_res.ready),
		.out_valid          (out_res.valid),
		.out_kind           (out_res.result_kind),
		.out_total          (out_res.packet_total),
		.out_addr           (out_res.blocked_addr),
		.out_last           (out_res.last_result)
	);

endmodule

FILE: hdl/fwst_checker.sv
`timescale 1ns / 1ps
`include "flood_window_source_tracker_core_macros.svh"

module fwst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [31:0] packet_total,
	input logic        last_result
);

	// A stalled word stays on the output.
	`FWST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// A quiet verdict ends the results of its packet.
	`FWST_ASSERT_IMPLY(a_quiet_last, clk, arst_n,
		out_valid && (result_kind == fwst_pkg::KIND_QUIET), last_result)

	// While a window drains, no packet is taken.
	`FWST_ASSERT_IMPLY(a_drain_stall, clk, arst_n, out_valid && !last_result, !in_ready)

	// Source words carry no count.
	`FWST_ASSERT_IMPLY(a_block_total, clk, arst_n,
		out_valid && (result_kind == fwst_pkg::KIND_BLOCK), packet_total == 32'd0)

endmodule

bind flood_window_source_tracker_core fwst_checker u_fwst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_pkt.ready),
	.out_valid    (out_res.valid),
	.out_ready    (out_res.ready),
	.result_kind  (out_res.result_kind),
	.packet_total (out_res.packet_total),
	.last_result  (out_res.last_result)
);
